/* rtl/infix_to_postfix_converter_unit_macros.svh */
// Assertion macros for the infix-to-postfix converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, disabled while reset is high
`define I2P_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// overlapping implication, disabled while reset is high
`define I2P_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define I2P_ASSERT(lbl, clk, rst, prop, msg)
`define I2P_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/i2p_pkg.sv */
// Shared types and codes for the infix-to-postfix converter.
// No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  // input token kinds
  localparam logic [2:0] TOK_OPERAND = 3'd0;
  localparam logic [2:0] TOK_PLUS    = 3'd1;
  localparam logic [2:0] TOK_TIMES   = 3'd2;
  localparam logic [2:0] TOK_OPEN    = 3'd3;
  localparam logic [2:0] TOK_CLOSE   = 3'd4;
  localparam logic [2:0] TOK_END     = 3'd5;

  // result kinds
  localparam logic [1:0] OUT_OPERAND = 2'd0;
  localparam logic [1:0] OUT_PLUS    = 2'd1;
  localparam logic [1:0] OUT_TIMES   = 2'd2;
  localparam logic [1:0] OUT_END     = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED_CLOSE = 2'd2;
  localparam logic [1:0] ERR_UNMATCHED_OPEN  = 2'd3;

  // operator stack entries
  localparam logic [1:0] STK_PLUS  = 2'd1;
  localparam logic [1:0] STK_TIMES = 2'd2;
  localparam logic [1:0] STK_OPEN  = 2'd3;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_PLUS,
    CMD_TIMES,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_value;
    logic        last_of_run;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic {
    ST_RUN,
    ST_FINAL
  } back_state_t;

endpackage

/* rtl/infix_to_postfix_converter_unit.sv */
// Infix-to-postfix converter (shunting-yard), top level.
// Depends on i2p_pkg, i2p_front and i2p_back.
//
// Tokens enter on the in channel and are decoded into a two-entry command
// queue; a stack engine pops commands and drives a registered out channel.
// For each token the engine pops stack entries one at a time, then takes a
// further step for a push or for an operand, error or end-marker result (a
// close whose match is on top finishes in the cycle that discards the open
// parenthesis), and an extra step when the token popped any operator, to
// release its last held result. Output stalls add further steps. Token kinds
// 6 and 7 are dropped in the front end and cost the engine nothing. The
// operator stack sits in a memory with one write and one registered read
// port; its contents need no clearing after reset. A result that needs no
// pop passes through the command queue and the output register; a popped
// operator is held back further, until the next step shows whether it
// ends the token's results.
module infix_to_postfix_converter_unit import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  i2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/i2p_front.sv */
// Front end: takes input beats, decodes token kinds into commands and
// queues them (two entries) for the stack engine. Depends on i2p_pkg.
module i2p_front import i2p_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       known;
  logic       enq;
  cmd_t       cmd_in;

  always_comb begin
    known        = 1'b1;
    cmd_in.op    = CMD_OPERAND;
    cmd_in.value = 16'd0;
    case (in_item.token_kind)
      TOK_OPERAND: begin
        cmd_in.op    = CMD_OPERAND;
        cmd_in.value = in_item.operand_value;
      end
      TOK_PLUS:  cmd_in.op = CMD_PLUS;
      TOK_TIMES: cmd_in.op = CMD_TIMES;
      TOK_OPEN:  cmd_in.op = CMD_OPEN;
      TOK_CLOSE: cmd_in.op = CMD_CLOSE;
      TOK_END:   cmd_in.op = CMD_END;
      default:   known = 1'b0;  // unused kinds are dropped here
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign enq       = in_valid && in_ready && known;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, enq} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q[wr_ptr] <= cmd_in;
  end

endmodule

/* rtl/i2p_back.sv */
// Back end: operator stack engine and output register.
// Depends on i2p_pkg and the assertion macro header.
`include "infix_to_postfix_converter_unit_macros.svh"
module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [1:0]       mem [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [1:0]       top;
  out_item_t        held;
  logic             held_valid;
  logic             open_seen;
  back_state_t      state, state_next;

  logic             slot_free;
  logic             full;
  logic             empty;
  logic             pop_cond;
  logic             want_pop_emit, want_pop_quiet, want_term, want_end;
  out_item_t        term_item;
  out_item_t        top_item;
  logic             emit;
  out_item_t        emit_item;
  logic             pop_en, push_en, held_load, to_final, final_emit, open_seen_set;
  out_item_t        held_next;
  logic [1:0]       push_code;
  logic [CNT_W-1:0] rd_cnt;

  assign slot_free = !out_valid || out_ready;
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign rd_cnt    = count - CNT_W'(2);

  assign top_item.out_kind    = (top == STK_TIMES) ? OUT_TIMES : OUT_PLUS;
  assign top_item.out_value   = 16'd0;
  assign top_item.last_of_run = 1'b0;
  assign top_item.error_code  = ERR_NONE;

  // times pops only times; plus pops plus and times
  assign pop_cond = (top == STK_TIMES) || (cmd.op == CMD_PLUS && top == STK_PLUS);

  always_comb begin
    case (cmd.op)
      CMD_TIMES: push_code = STK_TIMES;
      CMD_OPEN:  push_code = STK_OPEN;
      default:   push_code = STK_PLUS;
    endcase
  end

  // classify what the current command wants this cycle
  always_comb begin
    want_pop_emit  = 1'b0;
    want_pop_quiet = 1'b0;
    want_term      = 1'b0;
    want_end       = 1'b0;
    open_seen_set  = 1'b0;
    term_item.out_kind    = OUT_OPERAND;
    term_item.out_value   = 16'd0;
    term_item.last_of_run = 1'b0;
    term_item.error_code  = ERR_NONE;
    if (state == ST_RUN && cmd_valid) begin
      case (cmd.op)
        CMD_OPERAND: begin
          want_term           = 1'b1;
          term_item.out_value = cmd.value;
        end
        CMD_PLUS, CMD_TIMES: begin
          if (!empty && pop_cond) begin
            want_pop_emit = 1'b1;
          end else if (full && !held_valid) begin
            want_term            = 1'b1;
            term_item.error_code = ERR_OVERFLOW;
          end else begin
            want_end = 1'b1;
          end
        end
        CMD_OPEN: begin
          if (full) begin
            want_term            = 1'b1;
            term_item.error_code = ERR_OVERFLOW;
          end else begin
            want_end = 1'b1;
          end
        end
        CMD_CLOSE: begin
          if (empty) begin
            want_term            = 1'b1;
            term_item.error_code = ERR_UNMATCHED_CLOSE;
          end else if (top == STK_OPEN) begin
            want_pop_quiet = 1'b1;
            want_end       = 1'b1;
          end else begin
            want_pop_emit = 1'b1;
          end
        end
        CMD_END: begin
          if (empty) begin
            want_term            = 1'b1;
            term_item.out_kind   = OUT_END;
            term_item.error_code = open_seen ? ERR_UNMATCHED_OPEN : ERR_NONE;
          end else if (top == STK_OPEN) begin
            want_pop_quiet = 1'b1;
            open_seen_set  = 1'b1;
          end else begin
            want_pop_emit = 1'b1;
          end
        end
        default: want_end = 1'b1;
      endcase
    end
  end

  // resolve the wants against the output slot; a result is held back in the
  // held register so its last_of_run flag is known when it leaves
  always_comb begin
    emit       = 1'b0;
    emit_item  = held;
    pop_en     = 1'b0;
    push_en    = 1'b0;
    held_load  = 1'b0;
    held_next  = top_item;
    to_final   = 1'b0;
    final_emit = 1'b0;
    cmd_pop    = 1'b0;
    emit_item.last_of_run = 1'b0;
    if (state == ST_FINAL) begin
      if (slot_free) begin
        emit                  = 1'b1;
        final_emit            = 1'b1;
        emit_item.last_of_run = 1'b1;
      end
    end else begin
      if (want_pop_emit && (!held_valid || slot_free)) begin
        pop_en    = 1'b1;
        held_load = 1'b1;
        emit      = held_valid;
      end
      if (want_pop_quiet) pop_en = 1'b1;
      if (want_term && slot_free) begin
        cmd_pop = 1'b1;
        emit    = 1'b1;
        if (held_valid) begin
          held_load = 1'b1;
          held_next = term_item;
          to_final  = 1'b1;
        end else begin
          emit_item             = term_item;
          emit_item.last_of_run = 1'b1;
        end
      end
      if (want_end) begin
        cmd_pop  = 1'b1;
        push_en  = (cmd.op == CMD_PLUS) || (cmd.op == CMD_TIMES) || (cmd.op == CMD_OPEN);
        to_final = held_valid;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:   if (to_final) state_next = ST_FINAL;
      ST_FINAL: if (slot_free) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      count      <= '0;
      held_valid <= 1'b0;
      open_seen  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop_en) count <= count - CNT_W'(1);
      else if (push_en) count <= count + CNT_W'(1);
      if (held_load) held_valid <= 1'b1;
      else if (final_emit) held_valid <= 1'b0;
      if (cmd_pop) open_seen <= 1'b0;
      else if (open_seen_set) open_seen <= 1'b1;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // stack memory; top is the registered read of the entry below on a pop
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[count[IDX_W-1:0]] <= push_code;
      top <= push_code;
    end else if (pop_en && count >= CNT_W'(2)) begin
      top <= mem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (held_load) held <= held_next;
    if (emit) out_item <= emit_item;
  end

  `I2P_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `I2P_ASSERT_IMPL(a_final_held, clk, rst, state == ST_FINAL, held_valid, "final step without held result")
  `I2P_ASSERT_IMPL(a_push_room, clk, rst, push_en, !full, "push on full stack")
  `I2P_ASSERT(a_push_xor_pop, clk, rst, !(push_en && pop_en), "push and pop in one cycle")

endmodule
